// ===== hdl/lrfp_pkg.sv =====
`timescale 1ns / 1ps

package lrfp_pkg;

   // Sync pair that opens every response frame.
   localparam logic [7:0] SYNC_FIRST  = 8'hA5;
   localparam logic [7:0] SYNC_SECOND = 8'h5A;

   // Descriptor layout: four little-endian word bytes, then the type byte.
   localparam int DESC_BYTES   = 4;
   localparam int DESC_IDX_W   = $clog2(DESC_BYTES);
   localparam int DESC_CNT_W   = DESC_IDX_W + 1;
   localparam int SIZE_FIELD_W = 30;
   localparam int MODE_W       = 2;

   // Default width of payload sizes and indexes.
   localparam int SIZE_BITS_DEF = 10;

   // Payload limit register.
   localparam int                LIMIT_W     = 10;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd255;

   // Parser phase.
   typedef enum logic [1:0] {
      PH_HUNT_A5  = 2'd0,
      PH_HUNT_5A  = 2'd1,
      PH_DESC     = 2'd2,
      PH_PAYLOAD  = 2'd3
   } phase_type;

   // Result event codes.
   typedef enum logic [1:0] {
      EV_DATA  = 2'd0,
      EV_EMPTY = 2'd1,
      EV_ERROR = 2'd2
   } event_type;

   // Control part of one parser result.
   typedef struct packed {
      logic      valid;
      event_type ev;
      logic      last;
   } rsp_ctrl_type;

endpackage

// ===== hdl/lrfp_ifs.sv =====
`timescale 1ns / 1ps

// Received byte channel.
interface lrfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

// Parser result channel.
interface lrfp_rsp_if #(
   parameter int SIZE_BITS = lrfp_pkg::SIZE_BITS_DEF
);
   logic                     valid;
   logic                     ready;
   lrfp_pkg::event_type      event_res;
   logic [7:0]               data_byte;
   logic [SIZE_BITS-1:0]     byte_index;
   logic                     last;
   logic [SIZE_BITS-1:0]     frame_size;
   logic [1:0]               resp_mode;
   logic [7:0]               response_type;

   modport source (output valid, output event_res, output data_byte, output byte_index,
                   output last, output frame_size, output resp_mode,
                   output response_type, input ready);
   modport sink (input valid, input event_res, input data_byte, input byte_index,
                 input last, input frame_size, input resp_mode,
                 input response_type, output ready);
endinterface

// Payload limit register write channel.
interface lrfp_csr_if;
   logic                          valid;
   logic                          ready;
   logic [lrfp_pkg::LIMIT_W-1:0] payload_limit;

   modport source (output valid, output payload_limit, input ready);
   modport sink (input valid, input payload_limit, output ready);
endinterface

// ===== hdl/lrfp_parser.sv =====
`timescale 1ns / 1ps

module lrfp_parser #(
   parameter int SIZE_BITS = lrfp_pkg::SIZE_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic [7:0]                     rx_byte,
   input  logic [lrfp_pkg::LIMIT_W-1:0]   limit,
   output lrfp_pkg::rsp_ctrl_type         ctrl,
   output logic [7:0]                     data_byte,
   output logic [SIZE_BITS-1:0]           byte_index,
   output logic [SIZE_BITS-1:0]           frame_size,
   output logic [lrfp_pkg::MODE_W-1:0]    resp_mode,
   output logic [7:0]                     response_type
);
   import lrfp_pkg::*;

   phase_type                phase_ff, phase_in;
   logic [7:0]               desc_ff [DESC_BYTES];
   logic [DESC_CNT_W-1:0]    desc_cnt_ff, desc_cnt_in;
   logic [SIZE_BITS-1:0]     pay_cnt_ff, pay_cnt_in;
   logic [SIZE_BITS-1:0]     held_size_ff, held_size_in;
   logic [MODE_W-1:0]        held_mode_ff, held_mode_in;
   logic [7:0]               held_type_ff, held_type_in;

   logic                     desc_full;
   logic [SIZE_FIELD_W-1:0]  word_size;
   logic [MODE_W-1:0]        word_mode;
   logic [SIZE_FIELD_W-1:0]  limit_ext;
   logic [SIZE_FIELD_W-1:0]  size_max_ext;
   logic [SIZE_FIELD_W-1:0]  limit_eff;
   logic [SIZE_FIELD_W-1:0]  size_sat;
   logic                     too_big;
   logic                     size_zero;
   logic [SIZE_BITS:0]       pay_next;
   logic                     pay_done;

   // Descriptor word decode and size checks.
   assign desc_full    = (desc_cnt_ff == DESC_CNT_W'(DESC_BYTES));
   assign word_size    = {desc_ff[3][5:0], desc_ff[2], desc_ff[1], desc_ff[0]};
   assign word_mode    = desc_ff[3][7:6];
   assign limit_ext    = SIZE_FIELD_W'(limit);
   assign size_max_ext = SIZE_FIELD_W'({SIZE_BITS{1'b1}});
   assign limit_eff    = (limit_ext > size_max_ext) ? size_max_ext : limit_ext;
   assign size_sat     = (word_size > size_max_ext) ? size_max_ext : word_size;
   assign too_big      = (word_size > limit_eff);
   assign size_zero    = (word_size == '0);

   // Payload position tracking.
   assign pay_next = {1'b0, pay_cnt_ff} + (SIZE_BITS+1)'(1);
   assign pay_done = (pay_next >= {1'b0, held_size_ff});

   // Next state.
   always_comb begin
      phase_in     = phase_ff;
      desc_cnt_in  = desc_cnt_ff;
      pay_cnt_in   = pay_cnt_ff;
      held_size_in = held_size_ff;
      held_mode_in = held_mode_ff;
      held_type_in = held_type_ff;
      if (step) begin
         unique case (phase_ff)
            PH_HUNT_A5: begin
               if (rx_byte == SYNC_FIRST) phase_in = PH_HUNT_5A;
            end
            PH_HUNT_5A: begin
               if (rx_byte == SYNC_SECOND) begin
                  phase_in    = PH_DESC;
                  desc_cnt_in = '0;
               end else if (rx_byte != SYNC_FIRST) begin
                  phase_in = PH_HUNT_A5;
               end
            end
            PH_DESC: begin
               if (!desc_full) begin
                  desc_cnt_in = desc_cnt_ff + DESC_CNT_W'(1);
               end else begin
                  held_mode_in = word_mode;
                  held_type_in = rx_byte;
                  if (too_big || size_zero) begin
                     held_size_in = size_sat[SIZE_BITS-1:0];
                     phase_in     = PH_HUNT_A5;
                     desc_cnt_in  = '0;
                     pay_cnt_in   = '0;
                  end else begin
                     held_size_in = word_size[SIZE_BITS-1:0];
                     pay_cnt_in   = '0;
                     phase_in     = PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               if (pay_done) begin
                  phase_in    = PH_HUNT_A5;
                  desc_cnt_in = '0;
                  pay_cnt_in  = '0;
               end else begin
                  pay_cnt_in = pay_next[SIZE_BITS-1:0];
               end
            end
         endcase
      end
   end

   // Result for the byte taken in this cycle.
   always_comb begin
      ctrl          = '{valid: 1'b0, ev: EV_DATA, last: 1'b0};
      data_byte     = '0;
      byte_index    = '0;
      frame_size    = '0;
      resp_mode     = held_mode_ff;
      response_type = held_type_ff;
      if (step) begin
         unique case (phase_ff) inside
            PH_HUNT_A5, PH_HUNT_5A: begin
               ctrl.valid = 1'b0;
            end
            PH_DESC: begin
               resp_mode     = word_mode;
               response_type = rx_byte;
               if (desc_full && too_big) begin
                  ctrl       = '{valid: 1'b1, ev: EV_ERROR, last: 1'b1};
                  frame_size = size_sat[SIZE_BITS-1:0];
               end else if (desc_full && size_zero) begin
                  ctrl = '{valid: 1'b1, ev: EV_EMPTY, last: 1'b1};
               end
            end
            PH_PAYLOAD: begin
               ctrl       = '{valid: 1'b1, ev: EV_DATA, last: pay_done};
               data_byte  = rx_byte;
               byte_index = pay_cnt_ff;
               frame_size = held_size_ff;
            end
         endcase
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT_A5;
         desc_cnt_ff  <= '0;
         pay_cnt_ff   <= '0;
         held_size_ff <= '0;
         held_mode_ff <= '0;
         held_type_ff <= '0;
      end else begin
         phase_ff     <= phase_in;
         desc_cnt_ff  <= desc_cnt_in;
         pay_cnt_ff   <= pay_cnt_in;
         held_size_ff <= held_size_in;
         held_mode_ff <= held_mode_in;
         held_type_ff <= held_type_in;
      end
   end

   // Descriptor word bytes are written before they are ever read.
   always_ff @(posedge clock) begin
      if (step && (phase_ff == PH_DESC) && !desc_full) begin
         desc_ff[desc_cnt_ff[DESC_IDX_W-1:0]] <= rx_byte;
      end
   end

endmodule

// ===== hdl/lidar_response_frame_parser.sv =====
// A result is registered and appears on rsp in the cycle after the byte that causes it is accepted.
// Throughput: one received byte per cycle while the result register is empty or being drained;
// the single result register is refilled in the same cycle that the downstream side takes its contents.
// Reset (synchronous, active high) returns the parser to the sync hunt, clears the
// result register and sets the payload limit to 255.
`timescale 1ns / 1ps

module lidar_response_frame_parser #(
   parameter int SIZE_BITS = lrfp_pkg::SIZE_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   lrfp_req_if.sink     req,
   lrfp_rsp_if.source   rsp,
   lrfp_csr_if.sink     csr
);
   import lrfp_pkg::*;

   logic [LIMIT_W-1:0]     limit_ff;
   logic                   req_fire;
   rsp_ctrl_type           ctrl;
   logic [7:0]             data_byte;
   logic [SIZE_BITS-1:0]   byte_index;
   logic [SIZE_BITS-1:0]   frame_size;
   logic [MODE_W-1:0]      resp_mode;
   logic [7:0]             response_type;

   logic                   rsp_valid_ff;
   event_type              rsp_event_ff;
   logic [7:0]             rsp_data_ff;
   logic [SIZE_BITS-1:0]   rsp_index_ff;
   logic                   rsp_last_ff;
   logic [SIZE_BITS-1:0]   rsp_size_ff;
   logic [MODE_W-1:0]      rsp_mode_ff;
   logic [7:0]             rsp_type_ff;

   // A request is taken whenever the result register is empty or being drained.
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign req_fire  = req.valid && req.ready;
   assign csr.ready = 1'b1;

   // Payload limit register.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr.valid) begin
         limit_ff <= csr.payload_limit;
      end
   end

   lrfp_parser #(
      .SIZE_BITS (SIZE_BITS)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .step          (req_fire),
      .rx_byte       (req.rx_byte),
      .limit         (limit_ff),
      .ctrl          (ctrl),
      .data_byte     (data_byte),
      .byte_index    (byte_index),
      .frame_size    (frame_size),
      .resp_mode     (resp_mode),
      .response_type (response_type)
   );

   // Result register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= ctrl.valid;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result register payload.
   always_ff @(posedge clock) begin
      if (req_fire && ctrl.valid) begin
         rsp_event_ff <= ctrl.ev;
         rsp_last_ff  <= ctrl.last;
         rsp_data_ff  <= data_byte;
         rsp_index_ff <= byte_index;
         rsp_size_ff  <= frame_size;
         rsp_mode_ff  <= resp_mode;
         rsp_type_ff  <= response_type;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.event_res     = rsp_event_ff;
   assign rsp.data_byte     = rsp_data_ff;
   assign rsp.byte_index    = rsp_index_ff;
   assign rsp.last          = rsp_last_ff;
   assign rsp.frame_size    = rsp_size_ff;
   assign rsp.resp_mode     = rsp_mode_ff;
   assign rsp.response_type = rsp_type_ff;

`ifndef ASSERT_OFF
   // A size error always closes the frame.
   a_error_last: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && (rsp.event_res == EV_ERROR)) |-> rsp.last)
      else $error("size error result without last");

   // An empty response carries a zero size and closes the frame.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && (rsp.event_res == EV_EMPTY)) |-> (rsp.last && (rsp.frame_size == '0)))
      else $error("empty response result is malformed");

   // A payload byte always lies inside the announced payload.
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && (rsp.event_res == EV_DATA)) |-> (rsp.byte_index < rsp.frame_size))
      else $error("payload byte index beyond payload size");

   // A stalled result is not overwritten by a new request.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |-> !req_fire)
      else $error("request accepted while result register is full");
`endif

endmodule

// ===== dv/lrfp_frame_checker.sv =====
`timescale 1ns / 1ps

// Scoreboard for the response frame parser. It follows every request on the byte
// channel with its own copy of the parser state and checks each result in order.
module lrfp_frame_checker (
   input  logic clock,
   input  logic reset,
   lrfp_req_if  req,
   lrfp_rsp_if  rsp,
   lrfp_csr_if  csr,
   output int   mismatches,
   output int   outstanding,
   output int   payload_seen,
   output int   empty_seen,
   output int   error_seen
);
   import lrfp_pkg::*;

   localparam int          SIZE_W   = SIZE_BITS_DEF;
   localparam int unsigned SIZE_TOP = (1 << SIZE_W) - 1;

   typedef struct packed {
      event_type         ev;
      logic [7:0]        data_byte;
      logic [SIZE_W-1:0] byte_index;
      logic              last;
      logic [SIZE_W-1:0] frame_size;
      logic [1:0]        resp_mode;
      logic [7:0]        response_type;
   } frame_result_type;

   // Parser state as the block should hold it.
   logic [LIMIT_W-1:0]    limit_reg;
   phase_type             phase;
   logic [7:0]            word_bytes [DESC_BYTES];
   logic [DESC_CNT_W-1:0] word_count;
   logic [SIZE_W-1:0]     payload_pos;
   logic [SIZE_W-1:0]     held_size;
   logic [1:0]            held_mode;
   logic [7:0]            held_type;
   frame_result_type      expected_q [$];

   function automatic frame_result_type make_result(input event_type ev, input logic [7:0] data,
                                                    input logic [SIZE_W-1:0] idx,
                                                    input logic last,
                                                    input logic [SIZE_W-1:0] size);
      frame_result_type r;
      r.ev            = ev;
      r.data_byte     = data;
      r.byte_index    = idx;
      r.last          = last;
      r.frame_size    = size;
      r.resp_mode     = held_mode;
      r.response_type = held_type;
      return r;
   endfunction

   // A frame is over, or was rejected: go back to hunting for the sync pair.
   function automatic void restart_hunt();
      phase       = PH_HUNT_A5;
      word_count  = '0;
      payload_pos = '0;
   endfunction

   // Advances the parser by one received byte; returns 1 when it yields a result.
   function automatic bit parse_byte(input logic [7:0] b, output frame_result_type r);
      logic [31:0]             word;
      logic [SIZE_FIELD_W-1:0] size_field;
      int unsigned             lim;
      bit                      done;
      r = '0;
      case (phase)
         PH_HUNT_A5: begin
            if (b == SYNC_FIRST) phase = PH_HUNT_5A;
         end
         PH_HUNT_5A: begin
            if (b == SYNC_SECOND) begin
               phase      = PH_DESC;
               word_count = '0;
            end else if (b != SYNC_FIRST) begin
               phase = PH_HUNT_A5;
            end
         end
         PH_DESC: begin
            if (word_count < DESC_BYTES) begin
               word_bytes[word_count[DESC_IDX_W-1:0]] = b;
               word_count = word_count + 1'b1;
               return 1'b0;
            end
            // The type byte closes the descriptor.
            word       = {word_bytes[3], word_bytes[2], word_bytes[1], word_bytes[0]};
            size_field = word[SIZE_FIELD_W-1:0];
            held_mode  = word[31:30];
            held_type  = b;
            lim = (limit_reg > SIZE_TOP) ? SIZE_TOP : limit_reg;
            if (size_field > lim) begin
               held_size = (size_field > SIZE_TOP) ? SIZE_W'(SIZE_TOP) : size_field[SIZE_W-1:0];
               r = make_result(EV_ERROR, 8'h00, '0, 1'b1, held_size);
               restart_hunt();
               return 1'b1;
            end
            held_size = size_field[SIZE_W-1:0];
            if (size_field == 0) begin
               r = make_result(EV_EMPTY, 8'h00, '0, 1'b1, '0);
               restart_hunt();
               return 1'b1;
            end
            payload_pos = '0;
            phase       = PH_PAYLOAD;
         end
         default: begin
            // Payload bytes stream straight through with their position.
            done = (int'(payload_pos) + 1 >= int'(held_size));
            r = make_result(EV_DATA, b, payload_pos, done, held_size);
            if (done) restart_hunt();
            else payload_pos = payload_pos + 1'b1;
            return 1'b1;
         end
      endcase
      return 1'b0;
   endfunction

   function automatic void check_field(input string field, input int unsigned want,
                                       input int unsigned seen);
      if (want != seen) begin
         $error("%s mismatch: expected %0d, actual %0d", field, want, seen);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : track
      frame_result_type want;
      frame_result_type fresh;
      if (reset) begin
         limit_reg = LIMIT_RESET;
         held_size = '0;
         held_mode = '0;
         held_type = '0;
         restart_hunt();
         expected_q.delete();
         mismatches   = 0;
         payload_seen = 0;
         empty_seen   = 0;
         error_seen   = 0;
      end else begin
         // Results leave first, since each one stems from an earlier request.
         if (rsp.valid && rsp.ready) begin
            if (expected_q.size() == 0) begin
               $error("result with nothing expected: event %0d, data %0d, index %0d",
                      rsp.event_res, rsp.data_byte, rsp.byte_index);
               mismatches++;
            end else begin
               want = expected_q.pop_front();
               check_field("event_res", want.ev, rsp.event_res);
               check_field("data_byte", want.data_byte, rsp.data_byte);
               check_field("byte_index", want.byte_index, rsp.byte_index);
               check_field("last", want.last, rsp.last);
               check_field("frame_size", want.frame_size, rsp.frame_size);
               check_field("resp_mode", want.resp_mode, rsp.resp_mode);
               check_field("response_type", want.response_type, rsp.response_type);
               case (want.ev)
                  EV_DATA:  payload_seen++;
                  EV_EMPTY: empty_seen++;
                  default:  error_seen++;
               endcase
            end
         end
         if (csr.valid && csr.ready) limit_reg = csr.payload_limit;
         if (req.valid && req.ready) begin
            if (parse_byte(req.rx_byte, fresh)) expected_q.push_back(fresh);
         end
      end
      outstanding <= expected_q.size();
   end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

// Drives framed byte streams into the parser under several payload limits while
// the checker beside it predicts and compares every result.
module tb;
   import lrfp_pkg::*;

   localparam int          HALF_PERIOD     = 6;
   localparam int          RESET_CYCLES    = 6;
   localparam int          PHASE_BYTES     = 70;
   localparam int          HOLD_OFF_CYCLES = 300;
   localparam int          STALL_LIMIT     = 2000;
   localparam int          SETTLE_CYCLES   = 4;
   localparam int unsigned SIZE_TOP        = (1 << SIZE_BITS_DEF) - 1;
   localparam int unsigned SIZE_FIELD_TOP  = (1 << SIZE_FIELD_W) - 1;

   // Opening sequence: ignored noise, a sync miss, a repeated first sync byte with
   // an empty response, a saturated oversize descriptor and a two-byte payload.
   localparam logic [7:0] OPENING [28] = '{
      8'h00, 8'hFF,
      SYNC_FIRST, 8'h13,
      SYNC_FIRST, SYNC_FIRST, SYNC_SECOND, 8'h00, 8'h00, 8'h00, 8'hC0, 8'hFF,
      SYNC_FIRST, SYNC_SECOND, 8'hFF, 8'hFF, 8'hFF, 8'h3F, 8'h80,
      SYNC_FIRST, SYNC_SECOND, 8'h02, 8'h00, 8'h00, 8'h40, 8'h00, 8'hFF, 8'h00
   };

   logic clock = 1'b0;
   logic reset;

   int bytes_sent;
   int quiet_cycles = 0;
   bit steady_flow  = 1'b0;
   bit hold_off_due = 1'b0;

   int mismatch_count;
   int outstanding;
   int payload_seen;
   int empty_seen;
   int error_seen;

   lrfp_req_if req_ch ();
   lrfp_rsp_if rsp_ch ();
   lrfp_csr_if csr_ch ();

   lidar_response_frame_parser DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   lrfp_frame_checker frame_check (
      .clock        (clock),
      .reset        (reset),
      .req          (req_ch),
      .rsp          (rsp_ch),
      .csr          (csr_ch),
      .mismatches   (mismatch_count),
      .outstanding  (outstanding),
      .payload_seen (payload_seen),
      .empty_seen   (empty_seen),
      .error_seen   (error_seen)
   );

   always #HALF_PERIOD clock = ~clock;

   // Receiver: random back-pressure, a clean stretch, and one long hold-off.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_due) begin
            hold_off_due = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= steady_flow || ($urandom_range(99) >= 32);
         end
      end
   end

   // Ends the run if no channel moves a request for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Offers one byte, with random idle cycles in front of it.
   task automatic push_byte(input logic [7:0] value);
      if (!steady_flow) begin
         while ($urandom_range(99) < 32) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      bytes_sent++;
   endtask

   // Stops sending and waits until every expected result has been taken.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      csr_ch.valid         <= 1'b1;
      csr_ch.payload_limit <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // Sync pair (sometimes with a repeated first byte), descriptor, type, payload.
   task automatic send_frame(input int unsigned size, input logic [1:0] mode,
                             input logic [7:0] rtype, input int unsigned body_len);
      logic [31:0] word;
      word = {mode, SIZE_FIELD_W'(size)};
      push_byte(SYNC_FIRST);
      if ($urandom_range(7) == 0) push_byte(SYNC_FIRST);
      push_byte(SYNC_SECOND);
      for (int i = 0; i < 4; i++) push_byte(word[8*i +: 8]);
      push_byte(rtype);
      repeat (body_len) push_byte(8'($urandom_range(255)));
   endtask

   // Mostly well-formed frames with random content, plus noise and broken syncs.
   task automatic send_random_frame(input int unsigned limit);
      int unsigned pick;
      int unsigned size;
      logic [7:0]  miss;
      pick = $urandom_range(99);
      if (pick < 8) begin
         repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(255)));
      end else if (pick < 14) begin
         push_byte(SYNC_FIRST);
         miss = 8'($urandom_range(255));
         if (miss == SYNC_SECOND) miss = ~miss;
         push_byte(miss);
      end else begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            size = 0;
         end else if (pick < 25) begin
            if (limit < SIZE_TOP && $urandom_range(1) == 1) size = $urandom_range(limit + 1, SIZE_TOP);
            else size = $urandom_range(SIZE_TOP + 1, SIZE_FIELD_TOP);
         end else if (pick < 32 && limit <= 64) begin
            size = limit;
         end else if (limit == 0) begin
            size = 0;
         end else begin
            size = $urandom_range(1, (limit < 24) ? limit : 24);
         end
         send_frame(size, 2'($urandom_range(3)), 8'($urandom_range(255)),
                    (size <= limit) ? size : 0);
      end
   endtask

   initial begin
      logic [LIMIT_W-1:0] limit_plan [6];
      int                 phase_start;
      bit                 mid_done;
      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.rx_byte       <= 8'h00;
      csr_ch.valid         <= 1'b0;
      csr_ch.payload_limit <= '0;
      bytes_sent = 0;
      limit_plan = '{10'd255, 10'd0, 10'd1023, 10'd1, 10'd40, 10'd0};
      limit_plan[5] = LIMIT_W'($urandom_range(2, 1022));
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed opening under the reset value of the limit.
      foreach (OPENING[i]) push_byte(OPENING[i]);

      for (int k = 0; k < 6; k++) begin
         drain_results();
         repeat (SETTLE_CYCLES) @(posedge clock);
         write_limit(limit_plan[k]);
         steady_flow = (k == 4);
         // A single full-size payload reaches the top byte index.
         if (limit_plan[k] == SIZE_TOP) begin
            send_frame(SIZE_TOP, 2'($urandom_range(3)), 8'($urandom_range(255)), SIZE_TOP);
         end
         phase_start = bytes_sent;
         mid_done    = 1'b0;
         while (bytes_sent - phase_start < PHASE_BYTES) begin
            send_random_frame(limit_plan[k]);
            if (!mid_done && bytes_sent - phase_start >= PHASE_BYTES / 2) begin
               mid_done = 1'b1;
               if (k == 0) drain_results();
               if (k == 5) hold_off_due = 1'b1;
            end
         end
      end
      steady_flow = 1'b0;

      drain_results();
      repeat (8) @(posedge clock);
      $display("Sent %0d bytes under the reset limit and six written limits (0 and 1023 too).",
               bytes_sent);
      $display("Checked %0d payload bytes, %0d empty responses and %0d size errors.",
               payload_seen, empty_seen, error_seen);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
